// ===== design/ise_pkg.sv =====
// ise_pkg: shared constants and controller/datapath interface types
// for the insertion sort engine; no dependencies
package ise_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

   // commands from controller to datapath
   typedef struct packed {
      logic capture;    // take request payload, pos <= count, idx <= 0
      logic rd_prev;    // read store at pos - 1
      logic shift;      // store[pos] <= read data, pos--
      logic place;      // store[pos] <= key, count++
      logic emit_rd;    // read store at idx
      logic emit_load;  // load response registers from read data
      logic emit_next;  // idx++
      logic finish;     // count <= 0
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic full;       // store holds MAX_ELEMENTS entries
      logic pos_zero;   // insert position reached the bottom
      logic greater;    // read entry is greater than key (signed)
      logic last_flag;  // request being inserted closes the list
      logic emit_last;  // response register holds the final element
   } status_type;

endpackage

// ===== design/ise_dpath.sv =====
// ise_dpath: element store, key/position/count registers, compare and
// response registers of the insertion sort engine; depends on ise_pkg
module ise_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  ise_pkg::cmd_type                    cmd,
   input  logic signed [ise_pkg::DATA_W-1:0]   req_value,
   input  logic                                req_last_item,
   output ise_pkg::status_type                 status,
   output logic signed [ise_pkg::DATA_W-1:0]   rsp_sorted_value,
   output logic                                rsp_last_out
);

   logic [ise_pkg::DATA_W-1:0] mem [ise_pkg::MAX_ELEMENTS];

   logic signed [ise_pkg::DATA_W-1:0] key_ff, key_in;
   logic                              last_ff, last_in;
   logic [ise_pkg::ADDR_W-1:0]        pos_ff, pos_in;
   logic [ise_pkg::ADDR_W-1:0]        idx_ff, idx_in;
   logic [ise_pkg::CNT_W-1:0]         count_ff, count_in;
   logic signed [ise_pkg::DATA_W-1:0] rd_data_ff;
   logic signed [ise_pkg::DATA_W-1:0] out_ff, out_in;
   logic                              out_last_ff, out_last_in;

   logic                       rd_en;
   logic [ise_pkg::ADDR_W-1:0] rd_addr;
   logic                       wr_en;
   logic [ise_pkg::DATA_W-1:0] wr_data;

   assign rd_en   = cmd.rd_prev | cmd.emit_rd;
   assign rd_addr = cmd.emit_rd ? idx_ff : pos_ff - 1'b1;
   assign wr_en   = cmd.shift | cmd.place;
   assign wr_data = cmd.shift ? rd_data_ff : key_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      key_in      = key_ff;
      last_in     = last_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      if (cmd.capture) begin
         key_in  = req_value;
         last_in = req_last_item;
         pos_in  = count_ff[ise_pkg::ADDR_W-1:0];
         idx_in  = '0;
      end
      if (cmd.shift) begin
         pos_in = pos_ff - 1'b1;
      end
      if (cmd.place) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.emit_load) begin
         out_in      = rd_data_ff;
         out_last_in = ({1'b0, idx_ff} + 1'b1) == count_ff;
      end
      if (cmd.emit_next) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.finish) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      key_ff      <= key_in;
      last_ff     <= last_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign status.full      = count_ff == ise_pkg::CNT_W'(ise_pkg::MAX_ELEMENTS);
   assign status.pos_zero  = pos_ff == '0;
   assign status.greater   = rd_data_ff > key_ff;
   assign status.last_flag = last_ff;
   assign status.emit_last = out_last_ff;

   assign rsp_sorted_value = out_ff;
   assign rsp_last_out     = out_last_ff;

endmodule

// ===== design/ise_ctrl.sv =====
// ise_ctrl: sequencing state machine of the insertion sort engine
// depends on ise_pkg
module ise_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_item,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  ise_pkg::status_type status,
   output ise_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_INS_RD  = 3'd1;
   localparam logic [2:0] S_INS_CMP = 3'd2;
   localparam logic [2:0] S_EMIT_RD = 3'd3;
   localparam logic [2:0] S_EMIT_LD = 3'd4;
   localparam logic [2:0] S_EMIT_WT = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (!status.full) begin
                  state_in = S_INS_RD;
               end else if (req_last_item) begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_INS_RD: begin
            if (status.pos_zero) begin
               cmd.place = 1'b1;
               state_in  = status.last_flag ? S_EMIT_RD : S_IDLE;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (status.greater) begin
               cmd.shift = 1'b1;
               state_in  = S_INS_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = status.last_flag ? S_EMIT_RD : S_IDLE;
            end
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            cmd.emit_load = 1'b1;
            state_in      = S_EMIT_WT;
         end
         S_EMIT_WT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.emit_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/insertion_sort_engine_core.sv =====
// insertion_sort_engine_core: top level of the insertion sort engine
// depends on ise_pkg, ise_ctrl, ise_dpath
// each request is inserted into the already sorted store on arrival: larger entries are
// read and shifted up one at a time, then the key is placed (one store port)
// a request arriving with the store full is dropped
// after the last request, each element is read out and held until the response is taken
// synchronous active-high reset empties the list; store contents need no clearing
module insertion_sort_engine_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [ise_pkg::DATA_W-1:0]  req_value,
   input  logic                               req_last_item,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ise_pkg::DATA_W-1:0]  rsp_sorted_value,
   output logic                               rsp_last_out
);

   // command and status between sequencer and datapath
   ise_pkg::cmd_type    cmd;
   ise_pkg::status_type status;

   // sequencer: load/insert loop, then read out one element per response
   ise_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_ready     (req_ready),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath: element store, signed compare, response registers
   ise_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .status           (status),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out)
   );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for insertion_sort_engine_core, a list sorter with
// valid/ready request and response channels; depends on ise_pkg and the core
module tb;

   typedef logic signed [ise_pkg::DATA_W-1:0] elem_type;

   localparam elem_type MOST_NEGATIVE = {1'b1, {(ise_pkg::DATA_W-1){1'b0}}};
   localparam elem_type MOST_POSITIVE = {1'b0, {(ise_pkg::DATA_W-1){1'b1}}};
   localparam int       QUIET_LIMIT   = 2000;
   localparam int       DRAIN_CYCLES  = 20;
   localparam int       PHASE_ITEMS   = 12;

   // keeps the list being collected and the sorted values still owed
   class sort_scoreboard;
      elem_type    held_list[$];
      elem_type    sorted_due[$];
      bit          last_due[$];
      int unsigned error_count;

      function void note_request(elem_type value, bit last_item);
         elem_type key;
         int       i;
         int       pos;
         if (held_list.size() < ise_pkg::MAX_ELEMENTS) held_list.push_back(value);
         if (!last_item) return;
         // stable insertion sort of the held list
         for (i = 1; i < held_list.size(); i++) begin
            key = held_list[i];
            pos = i;
            while (pos > 0 && held_list[pos-1] > key) begin
               held_list[pos] = held_list[pos-1];
               pos--;
            end
            held_list[pos] = key;
         end
         for (i = 0; i < held_list.size(); i++) begin
            sorted_due.push_back(held_list[i]);
            last_due.push_back(i == held_list.size() - 1);
         end
         held_list.delete();
      endfunction

      function void check_response(elem_type value, bit last_out);
         elem_type exp_value;
         bit       exp_last;
         if (sorted_due.size() == 0) begin
            $display("%0t: unexpected response, value %0d last_out %0b",
                     $time, value, last_out);
            error_count++;
            return;
         end
         exp_value = sorted_due.pop_front();
         exp_last  = last_due.pop_front();
         if (value !== exp_value) begin
            $display("%0t: sorted_value expected %0d actual %0d",
                     $time, exp_value, value);
            error_count++;
         end
         if (last_out !== exp_last) begin
            $display("%0t: last_out expected %0b actual %0b",
                     $time, exp_last, last_out);
            error_count++;
         end
      endfunction

      function int pending();
         return sorted_due.size();
      endfunction
   endclass

   logic     clock         = 1'b0;
   logic     reset         = 1'b1;
   logic     req_valid     = 1'b0;
   logic     req_ready;
   elem_type req_value     = '0;
   logic     req_last_item = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready     = 1'b0;
   elem_type rsp_sorted_value;
   logic     rsp_last_out;

   sort_scoreboard sb;
   int       send_idle_pct;
   int       recv_stall_pct;
   int       quiet_cycles = 0;
   elem_type list_buf[$];

   insertion_sort_engine_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // random response back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // accepted requests feed the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_value, req_last_item);
   end

   // accepted responses are checked in order
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_sorted_value, rsp_last_out);
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("tb failed");
         $finish;
      end
   end

   // one request: optional idle gap, then hold valid until accepted
   task send_request(elem_type value, bit last_item);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_value     <= value;
      req_last_item <= last_item;
      do @(posedge clock); while (!req_ready);
   endtask

   // sends list_buf as one list, last flag on its final entry
   task send_buffer();
      int k;
      for (k = 0; k < list_buf.size(); k++) send_request(list_buf[k], k == list_buf.size() - 1);
   endtask

   // mostly full-range values, some extremes and a narrow band for duplicates
   function elem_type pick_value();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0:       return MOST_NEGATIVE;
               1:       return MOST_POSITIVE;
               2:       return elem_type'(0);
               3:       return elem_type'(-1);
               default: return elem_type'(1);
            endcase
         end
         1:       return elem_type'($urandom_range(0, 8)) - elem_type'(4);
         default: return elem_type'($urandom);
      endcase
   endfunction

   task send_random_list(int len);
      int k;
      list_buf.delete();
      for (k = 0; k < len; k++) list_buf.push_back(pick_value());
      send_buffer();
   endtask

   initial begin
      int phase;
      int sent;
      int len;
      sb             = new;
      send_idle_pct  = 33;
      recv_stall_pct = 55;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: single-element lists at both extremes
      list_buf = {MOST_POSITIVE};
      send_buffer();
      list_buf = {MOST_NEGATIVE};
      send_buffer();
      // extremes mixed with zero, ones and duplicates
      list_buf = {MOST_POSITIVE, MOST_NEGATIVE, elem_type'(0), elem_type'(-1), elem_type'(1),
                  elem_type'(5), elem_type'(5), elem_type'(-5), MOST_NEGATIVE, MOST_POSITIVE};
      send_buffer();
      // already ascending: no shifts
      list_buf = {elem_type'(1), elem_type'(2), elem_type'(3), elem_type'(4)};
      send_buffer();
      // descending: every insert shifts the whole list
      list_buf = {elem_type'(4), elem_type'(3), elem_type'(2), elem_type'(1)};
      send_buffer();
      // all equal
      list_buf = {elem_type'(7), elem_type'(7), elem_type'(7)};
      send_buffer();

      // random lists under three idle patterns
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 33; recv_stall_pct = 55; end
            1: begin send_idle_pct = 55; recv_stall_pct = 33; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = $urandom_range(1, 8);
            send_random_list(len);
            sent += len;
         end
         // overfull list: entries past the store size are dropped,
         // the final one included, and the held ones still come out
         if (phase == 1) begin
            send_random_list($urandom_range(ise_pkg::MAX_ELEMENTS + 1,
                                            ise_pkg::MAX_ELEMENTS + 4));
         end
      end
      req_valid <= 1'b0;

      // let the monitor record the final request before polling
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/ise_pkg.sv
design/ise_dpath.sv
design/ise_ctrl.sv
design/insertion_sort_engine_core.sv
sim/tb.sv
